[rtl/rhei_pkg.sv]
`default_nettype none

package rhei_pkg;

    // Widths and sizes
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 5;
    localparam int BURST_MAX = 14;
    localparam int CNT_W     = 4;
    localparam int HELD_N    = 3;

    // X bit of RTP byte 0
    localparam logic [BYTE_W-1:0] XBIT = 8'h10;

    // Byte positions inside fixed header and old extension header
    localparam logic [POS_W-1:0] POS_FIRST     = 5'd0;
    localparam logic [POS_W-1:0] POS_FIXED_END = 5'd11;
    localparam logic [POS_W-1:0] POS_EXT_FIRST = 5'd12;
    localparam logic [POS_W-1:0] POS_EXT_HI    = 5'd13;
    localparam logic [POS_W-1:0] POS_EXT_LAST  = 5'd15;
    localparam logic [POS_W-1:0] POS_SAT       = 5'd16;

    // New extension is 4*(3+t+w) bytes; too long once t+w reaches 61 (256 bytes)
    localparam logic [16:0] TW_LIMIT = 17'd61;

    // Element length fields
    localparam logic [3:0]        TSN_SHORT_LEN = 4'd1;
    localparam logic [BYTE_W-1:0] TSN_LONG_LEN  = 8'd2;
    localparam logic [15:0]       LEN_BASE      = 16'd2;
    localparam logic [BYTE_W-1:0] PRIV_LEN_ADJ  = 8'd4;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ONE_BYTE_PROFILE = 2'd0,
        REG_TWO_BYTE_PROFILE = 2'd1,
        REG_TSN_ID           = 2'd2,
        REG_PRIV_ID          = 2'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [15:0] ONE_BYTE_PROFILE_RST = 16'hBEDE;
    localparam logic [15:0] TWO_BYTE_PROFILE_RST = 16'h1000;
    localparam logic [3:0]  TSN_ID_RST           = 4'd1;
    localparam logic [7:0]  PRIV_ID_RST          = 8'd1;

    typedef struct packed {
        logic [15:0] one_byte_profile;
        logic [15:0] two_byte_profile;
        logic [3:0]  tsn_element_id;
        logic [7:0]  private_element_id;
    } cfg_t;

    // One output word
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              err;
    } word_t;

    typedef word_t [BURST_MAX-1:0] burst_t;

endpackage

`default_nettype wire

[rtl/rhei_cfg.sv]
`default_nettype none

module rhei_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    output rhei_pkg::cfg_t           cfg
);

    rhei_pkg::cfg_t cfg_reg;
    rhei_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (rhei_pkg::cfg_reg_t'(cfg_index))
                rhei_pkg::REG_ONE_BYTE_PROFILE: cfg_next.one_byte_profile   = cfg_data;
                rhei_pkg::REG_TWO_BYTE_PROFILE: cfg_next.two_byte_profile   = cfg_data;
                rhei_pkg::REG_TSN_ID:           cfg_next.tsn_element_id     = cfg_data[3:0];
                rhei_pkg::REG_PRIV_ID:          cfg_next.private_element_id = cfg_data[7:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_byte_profile   <= rhei_pkg::ONE_BYTE_PROFILE_RST;
            cfg_reg.two_byte_profile   <= rhei_pkg::TWO_BYTE_PROFILE_RST;
            cfg_reg.tsn_element_id     <= rhei_pkg::TSN_ID_RST;
            cfg_reg.private_element_id <= rhei_pkg::PRIV_ID_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rhei_ctx.sv]
`default_nettype none

// Packet context and burst builder: turns one input byte into 0..14 output words
module rhei_ctx (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [rhei_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                        in_last,
    input  wire logic                        add_tsn,
    input  wire logic [15:0]                 seq_number,
    input  wire rhei_pkg::cfg_t              cfg,
    output rhei_pkg::burst_t                 burst,
    output logic [rhei_pkg::CNT_W-1:0]       burst_cnt
);

    logic [rhei_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        had_reg, had_next;
    logic [7:0]                  rem_reg, rem_next;
    logic [16:0]                 tsn_reg, tsn_next;
    logic                        err_reg, err_next;
    logic [rhei_pkg::BYTE_W-1:0] held_reg [rhei_pkg::HELD_N];

    logic                        first;
    logic                        had;
    logic [rhei_pkg::BYTE_W-1:0] b;
    logic                        t;
    logic [15:0]                 seq;
    logic [15:0]                 w;
    logic [16:0]                 tw;
    logic                        len_err;
    logic [15:0]                 lw;
    logic [7:0]                  priv_len;
    logic [7:0]                  rem_dec;
    logic                        in_ext_hdr;
    logic                        held_we;
    logic                        trunc;
    logic [rhei_pkg::CNT_W-1:0]  n;

    function automatic rhei_pkg::word_t mk(input logic [7:0] d, input logic e);
        rhei_pkg::word_t r;
        r.data = d;
        r.last = 1'b0;
        r.err  = e;
        return r;
    endfunction

    // Shared terms
    assign first      = (pos_reg == rhei_pkg::POS_FIRST);
    assign had        = first ? in_byte[4] : had_reg;
    assign b          = first ? (in_byte | rhei_pkg::XBIT) : in_byte;
    assign t          = tsn_reg[16];
    assign seq        = tsn_reg[15:0];
    assign w          = {held_reg[2], in_byte};
    assign tw         = {1'b0, w} + {16'd0, t};
    assign len_err    = (tw >= rhei_pkg::TW_LIMIT);
    assign lw         = tw[15:0] + rhei_pkg::LEN_BASE;
    assign priv_len   = {w[5:0], 2'b00} + rhei_pkg::PRIV_LEN_ADJ;
    assign rem_dec    = rem_reg - 8'd1;
    assign in_ext_hdr = had && (pos_reg >= rhei_pkg::POS_EXT_FIRST)
                        && (pos_reg <= rhei_pkg::POS_EXT_LAST);
    assign held_we    = in_ext_hdr && (pos_reg != rhei_pkg::POS_EXT_LAST);

    // Burst build and next state
    always_comb
    begin
        burst    = '0;
        n        = '0;
        trunc    = 1'b0;
        pos_next = pos_reg;
        had_next = had;
        rem_next = rem_reg;
        tsn_next = tsn_reg;
        err_next = err_reg;

        if (first)
        begin
            tsn_next = {add_tsn, seq_number};
        end

        if (pos_reg < rhei_pkg::POS_EXT_FIRST)
        begin
            burst[n] = mk(b, 1'b0); n = n + 4'd1;
            if (pos_reg == rhei_pkg::POS_FIXED_END && !had)
            begin
                // fresh one-byte-form extension
                burst[n] = mk(cfg.one_byte_profile[15:8], 1'b0); n = n + 4'd1;
                burst[n] = mk(cfg.one_byte_profile[7:0], 1'b0);  n = n + 4'd1;
                burst[n] = mk(8'd0, 1'b0);                       n = n + 4'd1;
                burst[n] = mk({7'd0, t}, 1'b0);                  n = n + 4'd1;
                if (t)
                begin
                    burst[n] = mk({cfg.tsn_element_id, rhei_pkg::TSN_SHORT_LEN}, 1'b0);
                    n = n + 4'd1;
                    burst[n] = mk(seq[15:8], 1'b0); n = n + 4'd1;
                    burst[n] = mk(seq[7:0], 1'b0);  n = n + 4'd1;
                    burst[n] = mk(8'd0, 1'b0);      n = n + 4'd1;
                end
            end
            else
            begin
                trunc = 1'b1;
            end
        end
        else if (in_ext_hdr)
        begin
            if (pos_reg == rhei_pkg::POS_EXT_LAST)
            begin
                // two-byte-form header, wrapping the old extension
                burst[n] = mk(lw[15:8], len_err); n = n + 4'd1;
                burst[n] = mk(lw[7:0], len_err);  n = n + 4'd1;
                if (t)
                begin
                    burst[n] = mk({4'd0, cfg.tsn_element_id}, len_err); n = n + 4'd1;
                    burst[n] = mk(rhei_pkg::TSN_LONG_LEN, len_err);     n = n + 4'd1;
                    burst[n] = mk(seq[15:8], len_err);                  n = n + 4'd1;
                    burst[n] = mk(seq[7:0], len_err);                   n = n + 4'd1;
                end
                burst[n] = mk(cfg.private_element_id, len_err); n = n + 4'd1;
                burst[n] = mk(priv_len, len_err);               n = n + 4'd1;
                burst[n] = mk(held_reg[0], len_err);            n = n + 4'd1;
                burst[n] = mk(held_reg[1], len_err);            n = n + 4'd1;
                burst[n] = mk(held_reg[2], len_err);            n = n + 4'd1;
                burst[n] = mk(in_byte, len_err);                n = n + 4'd1;
                if (len_err)
                begin
                    err_next = 1'b1;
                    rem_next = 8'd0;
                end
                else if (w == 16'd0)
                begin
                    burst[n] = mk(8'd0, 1'b0); n = n + 4'd1;
                    burst[n] = mk(8'd0, 1'b0); n = n + 4'd1;
                end
                else
                begin
                    rem_next = {w[5:0], 2'b00};
                    trunc    = 1'b1;
                end
            end
            else if (in_last)
            begin
                burst[n] = mk(b, 1'b0); n = n + 4'd1;
                trunc    = 1'b1;
            end
            else if (pos_reg == rhei_pkg::POS_EXT_FIRST)
            begin
                burst[n] = mk(cfg.two_byte_profile[15:8], 1'b0); n = n + 4'd1;
            end
            else if (pos_reg == rhei_pkg::POS_EXT_HI)
            begin
                burst[n] = mk(cfg.two_byte_profile[7:0], 1'b0); n = n + 4'd1;
            end
        end
        else if (rem_reg != 8'd0)
        begin
            // old extension data, then two pad bytes
            burst[n] = mk(b, 1'b0); n = n + 4'd1;
            rem_next = rem_dec;
            if (rem_dec == 8'd0)
            begin
                burst[n] = mk(8'd0, 1'b0); n = n + 4'd1;
                burst[n] = mk(8'd0, 1'b0); n = n + 4'd1;
            end
            else
            begin
                trunc = 1'b1;
            end
        end
        else
        begin
            burst[n] = mk(b, err_reg); n = n + 4'd1;
        end

        // end of packet
        if (in_last)
        begin
            if (n != 4'd0)
            begin
                burst[n - 4'd1].last = 1'b1;
                if (trunc)
                begin
                    burst[n - 4'd1].err = 1'b1;
                end
            end
            pos_next = rhei_pkg::POS_FIRST;
            had_next = 1'b0;
            rem_next = 8'd0;
            err_next = 1'b0;
        end
        else
        begin
            pos_next = (pos_reg == rhei_pkg::POS_SAT) ? rhei_pkg::POS_SAT
                                                      : pos_reg + 5'd1;
        end
    end

    assign burst_cnt = n;

    // Context registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            had_reg <= 1'b0;
            rem_reg <= '0;
            tsn_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            had_reg <= had_next;
            rem_reg <= rem_next;
            tsn_reg <= tsn_next;
            err_reg <= err_next;
        end
    end

    // Held old extension header bytes
    always_ff @(posedge clk)
    begin
        if (accept && held_we)
        begin
            held_reg[pos_reg[1:0]] <= in_byte;
        end
    end

endmodule

`default_nettype wire

[rtl/rhei_burst.sv]
`default_nettype none

// Output queue: holds one burst and shifts it out one word per cycle while head_ready is high
module rhei_burst (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire rhei_pkg::burst_t            burst_in,
    input  wire logic [rhei_pkg::CNT_W-1:0]  cnt_in,
    output logic                             can_load,
    output logic                             head_valid,
    input  wire logic                        head_ready,
    output rhei_pkg::word_t                  head
);

    rhei_pkg::burst_t           q_reg;
    logic [rhei_pkg::CNT_W-1:0] count_reg;
    logic                       take;

    assign head_valid = (count_reg != '0);
    assign head       = q_reg[0];
    assign take       = head_valid && head_ready;
    // new burst may enter as the last queued word leaves
    assign can_load   = (count_reg == '0) || ((count_reg == 4'd1) && head_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= cnt_in;
        end
        else if (take)
        begin
            count_reg <= count_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= burst_in;
        end
        else if (take)
        begin
            q_reg <= {rhei_pkg::word_t'('0), q_reg[rhei_pkg::BURST_MAX-1:1]};
        end
    end

endmodule

`default_nettype wire

[rtl/rtp_header_extension_inserter.sv]
// Output: the first output word of an input word is registered in the output queue and appears in the cycle after
//   the input word is accepted. Each input word yields 0 to 14 output words, sent one per cycle while out_ready
//   is high; the output queue takes the next input word as its last queued word leaves.
// Reset: asynchronous, active low; clears packet context and the output queue and
//   loads the configuration registers with their defaults.
`default_nettype none

module rtp_header_extension_inserter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input packet bytes
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire logic        add_tsn,
    input  wire logic [15:0] seq_number,
    // output packet bytes
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             out_error
);

    rhei_pkg::cfg_t             cfg;
    rhei_pkg::burst_t           burst;
    logic [rhei_pkg::CNT_W-1:0] burst_cnt;
    logic                       accept;
    logic                       can_load;
    rhei_pkg::word_t            head;

    assign in_ready = can_load;
    assign accept   = in_valid && can_load;

    rhei_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rhei_ctx u_ctx (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .add_tsn    (add_tsn),
        .seq_number (seq_number),
        .cfg        (cfg),
        .burst      (burst),
        .burst_cnt  (burst_cnt)
    );

    rhei_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .burst_in   (burst),
        .cnt_in     (burst_cnt),
        .can_load   (can_load),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    assign out_byte  = head.data;
    assign out_last  = head.last;
    assign out_error = head.err;

endmodule

`default_nettype wire

[rtl/rhei_checker.sv]
`default_nettype none

module rhei_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic       in_last,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_last,
    input  wire logic       out_error
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
                                    && $stable(out_last) && $stable(out_error))
        else $error("output word changed while stalled");

    // empty queue always takes input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output queue");

    // no input while a stalled word waits
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // a packet's final byte always produces output
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> out_valid)
        else $error("final input word produced no output");

endmodule

bind rtp_header_extension_inserter rhei_checker u_rhei_checker (.*);

`default_nettype wire

[sim/rtp_header_extension_inserter_tb.sv]
`timescale 1ns / 1ps

module rtp_header_extension_inserter_tb;

    // Longest run of cycles with no handshake on any channel before giving up
    localparam int STALL_LIMIT   = 1000;
    // New extension at or above this many bytes marks the packet invalid
    localparam int EXT_MAX_BYTES = 256;
    // Cycles to let the block settle before a register write and at the end
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_WORDS   = 32;

    // One input word: a packet byte plus its side fields
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        tsn;
        logic [15:0] seq;
    } in_word_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = rhei_pkg::REG_ONE_BYTE_PROFILE;
    logic [15:0] cfg_data   = 16'd0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte    = 8'd0;
    logic        in_last    = 1'b0;
    logic        add_tsn    = 1'b0;
    logic [15:0] seq_number = 16'd0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        out_error;

    rtp_header_extension_inserter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .add_tsn    (add_tsn),
        .seq_number (seq_number),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .out_error  (out_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Packet bytes waiting to be sent, and rewritten words still to arrive
    in_word_t          pkt_feed[$];
    rhei_pkg::word_t   rewritten_words[$];

    // Shadow configuration
    logic [15:0] one_profile;
    logic [15:0] two_profile;
    logic [3:0]  tsn_id;
    logic [7:0]  priv_id;

    // Shadow packet context
    logic [4:0]  rx_pos;
    logic        rx_had_ext;
    logic [7:0]  rx_held[4];
    logic [7:0]  rx_ext_left;
    logic [16:0] rx_tsn;
    logic        rx_too_long;

    int n_fail       = 0;
    int n_pkts       = 0;
    int n_bad_pkts   = 0;
    int n_bytes_in   = 0;
    int n_words_out  = 0;
    int n_err_words  = 0;
    int n_queued     = 0;

    function automatic rhei_pkg::word_t mk_word(input logic [7:0] d, input logic e);
        rhei_pkg::word_t wd;
        wd.data = d;
        wd.last = 1'b0;
        wd.err  = e;
        return wd;
    endfunction

    // Mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Rewrite one accepted packet byte into the words it should produce
    task automatic rewrite_byte(input in_word_t w_in);
        rhei_pkg::word_t burst[$];
        rhei_pkg::word_t tail;
        logic [7:0]  b;
        logic [4:0]  pos;
        logic        t;
        logic        trunc;
        logic        err;
        logic [15:0] seq;
        logic [15:0] ext_len;
        logic [15:0] len_word;
        int          new_len;
        b     = w_in.data;
        pos   = rx_pos;
        trunc = 1'b0;
        if (pos == rhei_pkg::POS_FIRST)
        begin
            rx_tsn     = {w_in.tsn, w_in.seq};
            rx_had_ext = b[4];
            b          = b | rhei_pkg::XBIT;
        end
        t   = rx_tsn[16];
        seq = rx_tsn[15:0];

        if (pos <= rhei_pkg::POS_FIXED_END)
        begin
            burst.push_back(mk_word(b, 1'b0));
            if (pos == rhei_pkg::POS_FIXED_END && !rx_had_ext)
            begin
                // fresh one-byte-form extension
                burst.push_back(mk_word(one_profile[15:8], 1'b0));
                burst.push_back(mk_word(one_profile[7:0], 1'b0));
                burst.push_back(mk_word(8'd0, 1'b0));
                burst.push_back(mk_word({7'd0, t}, 1'b0));
                if (t)
                begin
                    burst.push_back(mk_word({tsn_id, rhei_pkg::TSN_SHORT_LEN}, 1'b0));
                    burst.push_back(mk_word(seq[15:8], 1'b0));
                    burst.push_back(mk_word(seq[7:0], 1'b0));
                    burst.push_back(mk_word(8'd0, 1'b0));
                end
            end
            else
                trunc = 1'b1;
        end
        else if (rx_had_ext && pos <= rhei_pkg::POS_EXT_LAST)
        begin
            rx_held[pos[1:0]] = b;
            if (pos == rhei_pkg::POS_EXT_LAST)
            begin
                // two-byte-form header, wrapping the old extension
                ext_len  = {rx_held[2], rx_held[3]};
                new_len  = 4 * (3 + int'(t) + int'(ext_len));
                err      = (new_len >= EXT_MAX_BYTES);
                len_word = rhei_pkg::LEN_BASE + {15'd0, t} + ext_len;
                burst.push_back(mk_word(len_word[15:8], err));
                burst.push_back(mk_word(len_word[7:0], err));
                if (t)
                begin
                    burst.push_back(mk_word({4'd0, tsn_id}, err));
                    burst.push_back(mk_word(rhei_pkg::TSN_LONG_LEN, err));
                    burst.push_back(mk_word(seq[15:8], err));
                    burst.push_back(mk_word(seq[7:0], err));
                end
                burst.push_back(mk_word(priv_id, err));
                burst.push_back(mk_word(rhei_pkg::PRIV_LEN_ADJ + {ext_len[5:0], 2'b00}, err));
                for (int i = 0; i < 4; i++)
                    burst.push_back(mk_word(rx_held[i], err));
                if (err)
                begin
                    rx_too_long = 1'b1;
                    rx_ext_left = 8'd0;
                end
                else if (ext_len == 16'd0)
                begin
                    burst.push_back(mk_word(8'd0, 1'b0));
                    burst.push_back(mk_word(8'd0, 1'b0));
                end
                else
                begin
                    rx_ext_left = {ext_len[5:0], 2'b00};
                    trunc       = 1'b1;
                end
            end
            else if (w_in.last)
            begin
                burst.push_back(mk_word(b, 1'b0));
                trunc = 1'b1;
            end
            else if (pos == rhei_pkg::POS_EXT_FIRST)
                burst.push_back(mk_word(two_profile[15:8], 1'b0));
            else if (pos == rhei_pkg::POS_EXT_HI)
                burst.push_back(mk_word(two_profile[7:0], 1'b0));
        end
        else if (rx_ext_left != 8'd0)
        begin
            // old extension data, padded once it runs out
            burst.push_back(mk_word(b, 1'b0));
            rx_ext_left = rx_ext_left - 8'd1;
            if (rx_ext_left == 8'd0)
            begin
                burst.push_back(mk_word(8'd0, 1'b0));
                burst.push_back(mk_word(8'd0, 1'b0));
            end
            else
                trunc = 1'b1;
        end
        else
            burst.push_back(mk_word(b, rx_too_long));

        if (w_in.last)
        begin
            if (burst.size() > 0)
            begin
                tail      = burst.pop_back();
                tail.last = 1'b1;
                if (trunc)
                    tail.err = 1'b1;
                burst.push_back(tail);
            end
            rx_pos      = rhei_pkg::POS_FIRST;
            rx_had_ext  = 1'b0;
            rx_ext_left = 8'd0;
            rx_too_long = 1'b0;
        end
        else if (rx_pos < rhei_pkg::POS_SAT)
            rx_pos = rx_pos + 5'd1;

        foreach (burst[i])
            rewritten_words.push_back(burst[i]);
    endtask

    // Packet byte driver
    int in_gap  = 0;
    int in_cnt  = 0;
    bit in_calm = 1'b0;
    in_word_t in_cur;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_byte    <= 8'd0;
            in_last    <= 1'b0;
            add_tsn    <= 1'b0;
            seq_number <= 16'd0;
            rx_pos      = rhei_pkg::POS_FIRST;
            rx_had_ext  = 1'b0;
            rx_ext_left = 8'd0;
            rx_tsn      = 17'd0;
            rx_too_long = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rewrite_byte(in_cur);
                n_bytes_in++;
                in_cnt++;
                if (in_cnt % 40 == 0)
                    in_calm = ($urandom_range(0, 2) == 0);
                in_gap = pick_gap(in_calm);
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pkt_feed.size() > 0)
                begin
                    in_cur      = pkt_feed.pop_front();
                    in_valid   <= 1'b1;
                    in_byte    <= in_cur.data;
                    in_last    <= in_cur.last;
                    add_tsn    <= in_cur.tsn;
                    seq_number <= in_cur.seq;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor and checker
    int              out_gap  = 0;
    bit              out_calm = 1'b0;
    rhei_pkg::word_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                n_words_out++;
                if (out_error)
                    n_err_words++;
                if (rewritten_words.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected word: byte %h last %b error %b",
                             $time, out_byte, out_last, out_error);
                end
                else
                begin
                    want = rewritten_words.pop_front();
                    if (out_byte !== want.data)
                    begin
                        n_fail++;
                        $display("%0t: out_byte mismatch: expected %h, got %h",
                                 $time, want.data, out_byte);
                    end
                    if (out_last !== want.last)
                    begin
                        n_fail++;
                        $display("%0t: out_last mismatch: expected %b, got %b",
                                 $time, want.last, out_last);
                    end
                    if (out_error !== want.err)
                    begin
                        n_fail++;
                        $display("%0t: out_error mismatch: expected %b, got %b",
                                 $time, want.err, out_error);
                    end
                end
                if (n_words_out % 40 == 0)
                    out_calm = ($urandom_range(0, 2) == 0);
                out_gap = pick_gap(out_calm);
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: too long with no handshake anywhere
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                $display("rtp_header_extension_inserter test failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Build one packet. cut: 0 keeps it whole, -1 truncates at random,
    // a positive value truncates it to that many bytes.
    task automatic queue_packet(input bit ext, input bit tsn, input logic [15:0] seq,
                                input logic [15:0] ext_words, input int pay_len,
                                input int cut);
        logic [7:0] pkt[$];
        logic [7:0] b;
        int         data_len;
        int         total;
        in_word_t   wd;
        b    = 8'($urandom);
        b[4] = ext;
        pkt.push_back(b);
        for (int i = 1; i < 12; i++)
            pkt.push_back(8'($urandom));
        if (ext)
        begin
            pkt.push_back(8'($urandom));
            pkt.push_back(8'($urandom));
            pkt.push_back(ext_words[15:8]);
            pkt.push_back(ext_words[7:0]);
            if (4 * (3 + int'(tsn) + int'(ext_words)) >= EXT_MAX_BYTES)
                data_len = $urandom_range(0, 6);
            else
                data_len = 4 * int'(ext_words);
            for (int i = 0; i < data_len; i++)
                pkt.push_back(8'($urandom));
        end
        for (int i = 0; i < pay_len; i++)
            pkt.push_back(8'($urandom));
        total = pkt.size();
        if (cut < 0)
            total = $urandom_range(1, total - 1);
        else if (cut > 0 && cut < total)
            total = cut;
        for (int i = 0; i < total; i++)
        begin
            wd.data = pkt[i];
            wd.last = (i == total - 1);
            wd.tsn  = (i == 0) ? tsn : 1'($urandom);
            wd.seq  = (i == 0) ? seq : 16'($urandom);
            pkt_feed.push_back(wd);
        end
        n_pkts++;
        n_queued += total;
        if (total < pkt.size() || (ext && 4 * (3 + int'(tsn) + int'(ext_words))
                                   >= EXT_MAX_BYTES))
            n_bad_pkts++;
    endtask

    task automatic queue_random_packet();
        int          kind;
        bit          tsn;
        logic [15:0] seq;
        int          pay;
        kind = $urandom_range(0, 99);
        tsn  = 1'($urandom_range(0, 1));
        seq  = 16'($urandom);
        pay  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (kind < 40)
            queue_packet(1'b0, tsn, seq, 16'd0, pay, 0);
        else if (kind < 78)
            queue_packet(1'b1, tsn, seq, 16'($urandom_range(0, 4)), pay, 0);
        else if (kind < 86)
        begin
            // overlong new extension, around the limit or far past it
            if ($urandom_range(0, 1))
                queue_packet(1'b1, 1'b1, seq, 16'd60, pay, 0);
            else if ($urandom_range(0, 1))
                queue_packet(1'b1, tsn, seq, 16'd61, pay, 0);
            else
                queue_packet(1'b1, tsn, seq, 16'($urandom_range(62, 65535)), pay, 0);
        end
        else
            queue_packet(1'($urandom_range(0, 1)), tsn, seq,
                         16'($urandom_range(0, 3)), pay, -1);
    endtask

    task automatic fill_random(input int n_words);
        int start;
        start = n_queued;
        while (n_queued - start < n_words)
            queue_random_packet();
    endtask

    // Let everything queued go in and every rewritten word come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pkt_feed.size() != 0 || in_valid || rewritten_words.size() != 0);
    endtask

    task automatic write_reg(input rhei_pkg::cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rhei_pkg::REG_ONE_BYTE_PROFILE: one_profile = val;
            rhei_pkg::REG_TWO_BYTE_PROFILE: two_profile = val;
            rhei_pkg::REG_TSN_ID:           tsn_id      = val[3:0];
            rhei_pkg::REG_PRIV_ID:          priv_id     = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] one, input logic [15:0] two,
                             input logic [3:0] tid, input logic [7:0] pid);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(rhei_pkg::REG_ONE_BYTE_PROFILE, one);
        write_reg(rhei_pkg::REG_TWO_BYTE_PROFILE, two);
        write_reg(rhei_pkg::REG_TSN_ID, {12'd0, tid});
        write_reg(rhei_pkg::REG_PRIV_ID, {8'd0, pid});
    endtask

    initial
    begin
        one_profile = rhei_pkg::ONE_BYTE_PROFILE_RST;
        two_profile = rhei_pkg::TWO_BYTE_PROFILE_RST;
        tsn_id      = rhei_pkg::TSN_ID_RST;
        priv_id     = rhei_pkg::PRIV_ID_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed packets under the reset configuration
        queue_packet(1'b0, 1'b1, 16'hFFFF, 16'd0, 0, 0);    // new extension, no payload
        queue_packet(1'b0, 1'b0, 16'h0000, 16'd0, 3, 0);    // new extension without TSN
        queue_packet(1'b1, 1'b1, 16'h5AC3, 16'd0, 0, 0);    // empty old extension, ends on pad
        queue_packet(1'b1, 1'b0, 16'h0001, 16'd1, 2, 0);    // one word of old extension
        queue_packet(1'b1, 1'b1, 16'h8000, 16'd60, 2, 0);   // at the length limit
        queue_packet(1'b1, 1'b0, 16'h7FFF, 16'hFFFF, 1, 0); // largest old length
        queue_packet(1'b0, 1'b1, 16'h1234, 16'd0, 0, 1);    // single-byte packet
        queue_packet(1'b1, 1'b0, 16'h4321, 16'd2, 0, 14);   // cut in old ext header
        queue_packet(1'b1, 1'b1, 16'hAAAA, 16'd2, 0, 18);   // cut in old ext data
        queue_packet(1'b1, 1'b0, 16'h5555, 16'd1, 0, 20);   // ends on last old ext byte
        queue_packet(1'b0, 1'b0, 16'h0F0F, 16'd0, 0, 8);    // cut in fixed header
        fill_random(PHASE_WORDS);

        // All-ones profile and private ID registers, TSN ID 14; sender holds off midway until the output drains
        write_all(16'hFFFF, 16'hFFFF, 4'd14, 8'd255);
        fill_random(PHASE_WORDS / 2);
        wait_drained();
        fill_random(PHASE_WORDS / 2);

        // Smallest registers, plus the longest old extension that still fits,
        // cut a few bytes into its data
        write_all(16'h0000, 16'h0000, 4'd1, 8'd1);
        queue_packet(1'b1, 1'b0, 16'hC0DE, 16'd60, 3, 24);
        fill_random(PHASE_WORDS);

        // Random registers
        write_all(16'($urandom), 16'($urandom), 4'($urandom_range(1, 14)),
                  8'($urandom_range(1, 255)));
        fill_random(PHASE_WORDS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d packets (%0d truncated or overlong) as %0d bytes;",
                 n_pkts, n_bad_pkts, n_bytes_in);
        $display("received %0d rewritten words, %0d of them flagged, over 4 settings.",
                 n_words_out, n_err_words);
        if (rewritten_words.size() != 0)
        begin
            n_fail++;
            $display("%0t: %0d expected words never arrived", $time,
                     rewritten_words.size());
        end
        if (n_fail == 0)
            $display("rtp_header_extension_inserter test passed");
        else
            $display("rtp_header_extension_inserter test failed");
        $finish;
    end

endmodule
